// File: src/ltc_pkg.sv
// ============================================================================
// ltc_pkg : shared types and constants of the lightmap texel combiner
// Word layouts of both channels, configuration register codes and the
// fixed widths of the internal light channels.
// ============================================================================
`default_nettype none

package ltc_pkg;

    // Internal channel width: 8.8 ambient plus static plus a 24-bit dynamic sum.
    localparam int CH_W      = 25;
    localparam int DYN_W     = 24;
    localparam int GAIN_W    = 18;
    localparam int SHIFT_W   = 4;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 18;

    localparam logic [GAIN_W-1:0] GAIN_RESET = 18'd6554;

    // Static lightmap kinds; the spare code means no static lightmap.
    localparam logic [1:0] MAP_NONE  = 2'd0;
    localparam logic [1:0] MAP_MONO  = 2'd1;
    localparam logic [1:0] MAP_RGB   = 2'd2;
    localparam logic [1:0] MAP_SPARE = 2'd3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_AMBIENT_FLOOR = 2'd0,
        CFG_STATIC_ADD    = 2'd1,
        CFG_SPECULAR_GAIN = 2'd2,
        CFG_LEVEL_SHIFT   = 2'd3
    } t_cfg_reg;

    typedef struct packed {
        logic [7:0]         ambient_floor;
        logic               static_add_enable;
        logic [GAIN_W-1:0]  specular_gain;
        logic [SHIFT_W-1:0] level_shift;
    } t_cfg;

    typedef struct packed {
        logic             first_texel;
        logic [31:0]      surface_light;
        logic [1:0]       map_kind;
        logic [7:0]       map_level;
        logic [7:0]       map_red;
        logic [7:0]       map_green;
        logic [7:0]       map_blue;
        logic [DYN_W-1:0] dyn_level;
        logic [DYN_W-1:0] dyn_red;
        logic [DYN_W-1:0] dyn_green;
        logic [DYN_W-1:0] dyn_blue;
        logic             dyn_tinted;
    } t_texel;

    typedef struct packed {
        logic [15:0] light_level;
        logic [15:0] light_red;
        logic [15:0] light_green;
        logic [15:0] light_blue;
        logic [15:0] add_red;
        logic [15:0] add_green;
        logic [15:0] add_blue;
        logic        surface_coloured;
        logic        surface_has_add;
    } t_light;

    typedef struct packed {
        logic            first_texel;
        logic            surface_coloured;
        logic [CH_W-1:0] ch_level;
        logic [CH_W-1:0] ch_red;
        logic [CH_W-1:0] ch_green;
        logic [CH_W-1:0] ch_blue;
    } t_mix;

endpackage

`default_nettype wire

// File: src/ltc_texel_if.sv
// ============================================================================
// ltc_texel_if : texel input channel
// Valid/ready channel that carries one lightmap texel word.
// ============================================================================
`default_nettype none

interface ltc_texel_if import ltc_pkg::*; ();
    logic   valid;
    logic   ready;
    t_texel word;

    modport source (output valid, output word, input ready);
    modport sink   (input valid, input word, output ready);
endinterface

`default_nettype wire

// File: src/ltc_light_if.sv
// ============================================================================
// ltc_light_if : combined light output channel
// Valid/ready channel that carries one combined light word.
// ============================================================================
`default_nettype none

interface ltc_light_if import ltc_pkg::*; ();
    logic   valid;
    logic   ready;
    t_light word;

    modport source (output valid, output word, input ready);
    modport sink   (input valid, input word, output ready);
endinterface

`default_nettype wire

// File: src/lightmap_texel_combiner.sv
// ============================================================================
// lightmap_texel_combiner : combined 8.8 light of one lightmap texel
// A word accepted at the input passes through the input, sum and result
// registers of the three-stage pipeline in turn before it is offered.
// Throughput: one texel word per cycle while the output is ready.
// Reset is synchronous and active low; it empties the pipeline, clears the
// running flags and loads the register defaults (gain 6554, others zero).
// ============================================================================
`default_nettype none

module lightmap_texel_combiner import ltc_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    ltc_texel_if.sink                 i_texel,
    ltc_light_if.source               o_light,
    input  wire logic                 i_cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_DAT_W-1:0] i_cfg_data
);

    // Configuration registers. The user must change them only while the block
    // is idle; the block does not enforce this, and each stage reads them directly.
    t_cfg r_cfg;

    // Running surface flags. The coloured flag is settled as a word leaves the
    // input register, the additive flag as it leaves the sum register; words
    // move through each stage in order, so each flag always belongs to the
    // word just ahead of the one being worked on.
    logic r_coloured;
    logic r_additive;

    // Pipeline registers and their valid bits.
    t_texel r_in;
    t_mix   r_mid;
    t_light r_out;
    logic   r_in_v, r_mid_v, r_out_v;

    t_mix   n_mid;
    t_light n_out;

    // Each stage can take a new word when it is empty or when its word moves
    // on in the same cycle. A waiting result therefore only holds the stages
    // that are actually full.
    logic out_free, mid_free, in_free;

    assign out_free = !r_out_v || o_light.ready;
    assign mid_free = !r_mid_v || out_free;
    assign in_free  = !r_in_v || mid_free;

    assign i_texel.ready = in_free;
    assign o_light.valid = r_out_v;
    assign o_light.word  = r_out;

    // First stage: ambient tint, static lightmap and dynamic sums.
    ltc_mix u_mix (
        .i_texel    (r_in),
        .i_cfg      (r_cfg),
        .i_col_prev (r_coloured && !r_in.first_texel),
        .o_mix      (n_mid)
    );

    // Second stage: specular overflow and output inversion.
    ltc_finish u_finish (
        .i_mix      (r_mid),
        .i_cfg      (r_cfg),
        .i_add_prev (r_additive && !r_mid.first_texel),
        .o_light    (n_out)
    );

    // Control state, flags and configuration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v     <= 1'b0;
            r_mid_v    <= 1'b0;
            r_out_v    <= 1'b0;
            r_coloured <= 1'b0;
            r_additive <= 1'b0;
            r_cfg.ambient_floor     <= 8'd0;
            r_cfg.static_add_enable <= 1'b0;
            r_cfg.specular_gain     <= GAIN_RESET;
            r_cfg.level_shift       <= '0;
        end else begin
            if (in_free) begin
                r_in_v <= i_texel.valid;
            end
            if (mid_free) begin
                r_mid_v <= r_in_v;
                if (r_in_v) begin
                    r_coloured <= n_mid.surface_coloured;
                end
            end
            if (out_free) begin
                r_out_v <= r_mid_v;
                if (r_mid_v) begin
                    r_additive <= n_out.surface_has_add;
                end
            end
            if (i_cfg_wr_en) begin
                unique case (t_cfg_reg'(i_cfg_index))
                    CFG_AMBIENT_FLOOR: r_cfg.ambient_floor     <= i_cfg_data[7:0];
                    CFG_STATIC_ADD:    r_cfg.static_add_enable <= i_cfg_data[0];
                    CFG_SPECULAR_GAIN: r_cfg.specular_gain     <= i_cfg_data[GAIN_W-1:0];
                    CFG_LEVEL_SHIFT:   r_cfg.level_shift       <= i_cfg_data[SHIFT_W-1:0];
                    default:           r_cfg                   <= r_cfg;
                endcase
            end
        end
    end

    // Payload registers carry no reset; their valid bits qualify them.
    always_ff @(posedge i_clk) begin
        if (in_free && i_texel.valid) begin
            r_in <= i_texel.word;
        end
        if (mid_free && r_in_v) begin
            r_mid <= n_mid;
        end
        if (out_free && r_mid_v) begin
            r_out <= n_out;
        end
    end

`ifndef SYNTH
    // A non-zero additive term must always raise the running additive flag.
    a_add_sets_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && (r_out.add_red != 16'd0 || r_out.add_green != 16'd0 ||
                     r_out.add_blue != 16'd0)) |-> r_out.surface_has_add)
        else $error("additive light without the additive flag");

    // The floor keeps every inverted channel at one or more.
    a_floor_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v |-> (r_out.light_level != 16'd0 && r_out.light_red != 16'd0 &&
                     r_out.light_green != 16'd0 && r_out.light_blue != 16'd0))
        else $error("inverted light channel below its floor");

    // Reset empties every pipeline stage.
    a_reset_empties: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> (!r_in_v && !r_mid_v && !r_out_v))
        else $error("pipeline not empty after reset");

    // A full sum stage that cannot advance keeps its word.
    a_mid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mid_v && !mid_free) |=> (r_mid_v && $stable(r_mid)))
        else $error("stalled sum stage lost its word");
`endif

endmodule

`default_nettype wire

// File: src/ltc_mix.sv
// ============================================================================
// ltc_mix : ambient, static and dynamic light sums
// Builds the tinted ambient level, adds the static lightmap with its clamp
// and adds the precomputed dynamic sums.
// ============================================================================
`default_nettype none

module ltc_mix import ltc_pkg::*; (
    input  t_texel i_texel,
    input  t_cfg   i_cfg,
    input  logic   i_col_prev,
    output t_mix   o_mix
);

    // colour * level * 256 / 255, floored; p + p/255 with an exact 16-bit reciprocal.
    function automatic logic [15:0] tint(input logic [7:0] colour, input logic [7:0] lvl);
        logic [15:0] p;
        logic [16:0] t;
        p = colour * lvl;
        t = {1'b0, p} + {9'b0, p[15:8]} + 17'd1;
        return p + {8'b0, t[15:8]};
    endfunction

    function automatic logic [16:0] clamp_add(input logic [15:0] base, input logic [15:0] add,
                                              input logic keep_wide);
        logic [16:0] s;
        s = {1'b0, base} + {1'b0, add};
        if (!keep_wide && s[16]) begin
            s = 17'h0ffff;
        end
        return s;
    endfunction

    logic [7:0]  lvl;
    logic [15:0] amb_r, amb_g, amb_b;
    logic        has_map, is_rgb;
    logic [15:0] m_word;
    logic [15:0] add_r, add_g, add_b;
    logic [16:0] lvl_s, red_s, green_s, blue_s;

    always_comb begin
        lvl = (i_texel.surface_light[31:24] < i_cfg.ambient_floor) ?
              i_cfg.ambient_floor : i_texel.surface_light[31:24];
        amb_r = tint(i_texel.surface_light[23:16], lvl);
        amb_g = tint(i_texel.surface_light[15:8], lvl);
        amb_b = tint(i_texel.surface_light[7:0], lvl);

        is_rgb  = (i_texel.map_kind == MAP_RGB);
        has_map = is_rgb || (i_texel.map_kind == MAP_MONO);
        m_word  = has_map ? {i_texel.map_level, 8'h00} : 16'h0000;
        add_r   = is_rgb ? {i_texel.map_red, 8'h00}   : m_word;
        add_g   = is_rgb ? {i_texel.map_green, 8'h00} : m_word;
        add_b   = is_rgb ? {i_texel.map_blue, 8'h00}  : m_word;

        lvl_s   = {1'b0, lvl, 8'h00} + {1'b0, m_word};
        red_s   = clamp_add(amb_r, add_r, i_cfg.static_add_enable);
        green_s = clamp_add(amb_g, add_g, i_cfg.static_add_enable);
        blue_s  = clamp_add(amb_b, add_b, i_cfg.static_add_enable);

        o_mix.first_texel      = i_texel.first_texel;
        o_mix.surface_coloured = i_col_prev || (amb_r != amb_g) || (amb_r != amb_b) ||
                                 is_rgb || i_texel.dyn_tinted;
        o_mix.ch_level = {8'b0, lvl_s}   + {1'b0, i_texel.dyn_level};
        o_mix.ch_red   = {8'b0, red_s}   + {1'b0, i_texel.dyn_red};
        o_mix.ch_green = {8'b0, green_s} + {1'b0, i_texel.dyn_green};
        o_mix.ch_blue  = {8'b0, blue_s}  + {1'b0, i_texel.dyn_blue};
    end

endmodule

`default_nettype wire

// File: src/ltc_finish.sv
// ============================================================================
// ltc_finish : specular overflow and output inversion
// Scales channel overflow above 0x10000 by the specular gain when the level
// shift is zero, then inverts, shifts and floors every channel.
// ============================================================================
`default_nettype none

module ltc_finish import ltc_pkg::*; (
    input  t_mix   i_mix,
    input  t_cfg   i_cfg,
    input  logic   i_add_prev,
    output t_light o_light
);

    localparam logic [CH_W-1:0] OVER_BASE  = CH_W'(32'h10000);
    localparam logic [15:0]     FULL_LIGHT = 16'hff00;

    function automatic logic [15:0] spec(input logic [CH_W-1:0] ch,
                                         input logic [GAIN_W-1:0] gain);
        logic [CH_W+GAIN_W-1:0] prod;
        logic [CH_W+GAIN_W-17:0] scaled;
        prod   = gain * (ch - OVER_BASE);
        scaled = prod[CH_W+GAIN_W-1:16];
        return (scaled > 16'hffff) ? 16'hffff : scaled[15:0];
    endfunction

    function automatic logic [15:0] invert(input logic [CH_W-1:0] ch,
                                           input logic [SHIFT_W-1:0] sh);
        logic [15:0] minl;
        logic [15:0] v;
        minl = 16'd1 << (SHIFT_W'(8) - sh);
        if (ch >= {9'b0, FULL_LIGHT}) begin
            v = minl;
        end else begin
            v = (FULL_LIGHT - ch[15:0]) >> sh;
            if (v < minl) begin
                v = minl;
            end
        end
        return v;
    endfunction

    logic [SHIFT_W-1:0] sh;
    logic spec_on, over_r, over_g, over_b;

    always_comb begin
        sh      = (i_cfg.level_shift > SHIFT_W'(8)) ? SHIFT_W'(8) : i_cfg.level_shift;
        spec_on = (i_cfg.level_shift == '0);
        over_r  = spec_on && (i_mix.ch_red > OVER_BASE);
        over_g  = spec_on && (i_mix.ch_green > OVER_BASE);
        over_b  = spec_on && (i_mix.ch_blue > OVER_BASE);

        o_light.light_level = invert(i_mix.ch_level, sh);
        o_light.light_red   = invert(i_mix.ch_red, sh);
        o_light.light_green = invert(i_mix.ch_green, sh);
        o_light.light_blue  = invert(i_mix.ch_blue, sh);
        o_light.add_red     = over_r ? spec(i_mix.ch_red, i_cfg.specular_gain)   : 16'h0000;
        o_light.add_green   = over_g ? spec(i_mix.ch_green, i_cfg.specular_gain) : 16'h0000;
        o_light.add_blue    = over_b ? spec(i_mix.ch_blue, i_cfg.specular_gain)  : 16'h0000;
        o_light.surface_coloured = i_mix.surface_coloured;
        o_light.surface_has_add  = i_add_prev || over_r || over_g || over_b;
    end

endmodule

`default_nettype wire

// File: tb/sv/lightmap_texel_combiner_test.sv
// ============================================================================
// lightmap_texel_combiner_test : self-checking bench of the texel combiner
// Streams texel words into the combiner under several register settings,
// works out every combined light word independently and compares the words
// that come out, field by field and in order.
// ============================================================================

module lightmap_texel_combiner_test;
    import ltc_pkg::*;

    // A generous ceiling on the run length; a correct run needs far less.
    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned PHASES      = 8;
    localparam int unsigned PHASE_WORDS = 244;
    localparam int unsigned HOLD_CYCLES = 80;

    // ------------------------------------------------------------------------
    // Ledger of combined light words. It keeps its own copy of the registers
    // and the running surface flags, works out the light word of every
    // accepted texel word and checks the output words against them in order.
    // ------------------------------------------------------------------------
    class light_ledger;
        t_light             lights_due[$];
        logic [7:0]         floor_level;
        logic               static_add;
        logic [GAIN_W-1:0]  gain;
        logic [SHIFT_W-1:0] shift;
        logic               coloured;
        logic               additive;
        int unsigned        faults;
        int unsigned        words_seen;

        function new();
            floor_level = 8'd0;
            static_add  = 1'b0;
            gain        = GAIN_RESET;
            shift       = '0;
            coloured    = 1'b0;
            additive    = 1'b0;
            faults      = 0;
            words_seen  = 0;
        endfunction

        function void set_register(t_cfg_reg idx, logic [CFG_DAT_W-1:0] d);
            case (idx)
                CFG_AMBIENT_FLOOR: floor_level = d[7:0];
                CFG_STATIC_ADD:    static_add  = d[0];
                CFG_SPECULAR_GAIN: gain        = d[GAIN_W-1:0];
                CFG_LEVEL_SHIFT:   shift       = d[SHIFT_W-1:0];
                default: ;
            endcase
        endfunction

        function int unsigned pending();
            return lights_due.size();
        endfunction

        function logic [31:0] clamp_colour(logic [31:0] v);
            if (!static_add && v > 32'hffff) return 32'hffff;
            return v;
        endfunction

        // Overflow above 0x10000 scaled by the 2.16 gain; any overflow at
        // all marks the surface additive, even when the scaled value is zero.
        function logic [15:0] specular(logic [31:0] ch);
            logic [63:0] p;
            if (ch <= 32'h10000) return 16'd0;
            additive = 1'b1;
            p = (64'(gain) * 64'(ch - 32'h10000)) >> 16;
            if (p > 64'hffff) return 16'hffff;
            return p[15:0];
        endfunction

        function logic [15:0] invert(logic [31:0] ch, int unsigned sh);
            logic [31:0] min_level;
            logic [31:0] v;
            min_level = 32'd1 << (8 - sh);
            if (ch >= 32'hff00) return min_level[15:0];
            v = (32'hff00 - ch) >> sh;
            return (v < min_level) ? min_level[15:0] : v[15:0];
        endfunction

        function void take_texel(t_texel w);
            logic [7:0]  amb;
            logic [31:0] lv, r, g, b, m;
            int unsigned sh;
            t_light      due;
            if (w.first_texel) begin
                coloured = 1'b0;
                additive = 1'b0;
            end
            amb = w.surface_light[31:24];
            if (amb < floor_level) amb = floor_level;
            lv = {16'd0, amb, 8'd0};
            r  = 32'(w.surface_light[23:16]) * lv / 32'd255;
            g  = 32'(w.surface_light[15:8]) * lv / 32'd255;
            b  = 32'(w.surface_light[7:0]) * lv / 32'd255;
            if (r != g || r != b) coloured = 1'b1;

            m = {16'd0, w.map_level, 8'd0};
            case (w.map_kind)
                MAP_RGB: begin
                    coloured = 1'b1;
                    lv += m;
                    r = clamp_colour(r + {16'd0, w.map_red, 8'd0});
                    g = clamp_colour(g + {16'd0, w.map_green, 8'd0});
                    b = clamp_colour(b + {16'd0, w.map_blue, 8'd0});
                end
                MAP_MONO: begin
                    lv += m;
                    r = clamp_colour(r + m);
                    g = clamp_colour(g + m);
                    b = clamp_colour(b + m);
                end
                default: ;
            endcase

            lv += 32'(w.dyn_level);
            r  += 32'(w.dyn_red);
            g  += 32'(w.dyn_green);
            b  += 32'(w.dyn_blue);
            if (w.dyn_tinted) coloured = 1'b1;

            due = '0;
            if (shift == '0) begin
                due.add_red   = specular(r);
                due.add_green = specular(g);
                due.add_blue  = specular(b);
            end
            sh = (shift > 4'd8) ? 8 : int'(shift);
            due.light_level      = invert(lv, sh);
            due.light_red        = invert(r, sh);
            due.light_green      = invert(g, sh);
            due.light_blue       = invert(b, sh);
            due.surface_coloured = coloured;
            due.surface_has_add  = additive;
            lights_due.push_back(due);
        endfunction

        task report(string msg);
            $display("ERROR: %s", msg);
            faults++;
        endtask

        task compare(string field, int unsigned got, int unsigned want);
            if (got != want)
                report($sformatf("light word %0d: %s is %0h, wanted %0h",
                                 words_seen, field, got, want));
        endtask

        task check_light(t_light got);
            t_light want;
            if (lights_due.size() == 0) begin
                report($sformatf("light word %0d arrived with nothing due", words_seen));
            end else begin
                want = lights_due.pop_front();
                compare("light_level", got.light_level, want.light_level);
                compare("light_red", got.light_red, want.light_red);
                compare("light_green", got.light_green, want.light_green);
                compare("light_blue", got.light_blue, want.light_blue);
                compare("add_red", got.add_red, want.add_red);
                compare("add_green", got.add_green, want.add_green);
                compare("add_blue", got.add_blue, want.add_blue);
                compare("surface_coloured", got.surface_coloured, want.surface_coloured);
                compare("surface_has_add", got.surface_has_add, want.surface_has_add);
            end
            words_seen++;
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and the block itself.
    // ------------------------------------------------------------------------
    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_wr_en;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_DAT_W-1:0] i_cfg_data;

    // When set, neither side idles at random: the stretch at full rate, but for a long receiver hold.
    logic                 steady = 1'b0;
    int unsigned          texels_in = 0;
    int unsigned          cycles = 0;
    int unsigned          hold_left = 0;
    int unsigned          hold_at = 600;

    light_ledger ledger = new();

    ltc_texel_if texel_ch ();
    ltc_light_if light_ch ();

    lightmap_texel_combiner dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_texel     (texel_ch),
        .o_light     (light_ch),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Both channels are sampled at the rising edge, before any of this
    // edge's nonblocking updates, so every accepted word is seen once and
    // with the values it was accepted with.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (texel_ch.valid && texel_ch.ready) begin
                ledger.take_texel(texel_ch.word);
                texels_in <= texels_in + 1;
            end
            if (light_ch.valid && light_ch.ready)
                ledger.check_light(light_ch.word);
        end
    end

    // Receiver. It stalls at random, except in the steady stretch, and twice
    // in the run it holds off for a long while, counted here, so that the
    // pipeline fills and the block has to refuse texel words.
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            light_ch.ready <= 1'b0;
        end else if (i_rst_n && texels_in >= hold_at) begin
            hold_left = HOLD_CYCLES;
            hold_at   = hold_at + 800;
            light_ch.ready <= 1'b0;
        end else begin
            light_ch.ready <= steady || ($urandom_range(0, 99) >= 31);
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------------

    // Offers one texel word and returns at the edge that accepts it. A word
    // that is to follow straight on keeps valid high; otherwise valid drops
    // for a short random gap.
    task automatic send_texel(input t_texel w);
        texel_ch.valid <= 1'b1;
        texel_ch.word  <= w;
        do @(posedge i_clk); while (!texel_ch.ready);
        if (!steady && $urandom_range(0, 99) < 31) begin
            texel_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
    endtask

    // Stops offering and waits until every light word due has come out.
    // The first edge lets the monitor note a word accepted at this edge.
    task automatic wait_drained();
        texel_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (ledger.pending() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_reg idx, input logic [CFG_DAT_W-1:0] d);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= d;
        @(posedge i_clk);
        ledger.set_register(idx, d);
    endtask

    // Writes all four registers on consecutive edges; only called when idle.
    task automatic load_config(input logic [7:0] floor_v, input logic add_v,
                               input logic [GAIN_W-1:0] gain_v,
                               input logic [SHIFT_W-1:0] shift_v);
        write_reg(CFG_AMBIENT_FLOOR, CFG_DAT_W'(floor_v));
        write_reg(CFG_STATIC_ADD, CFG_DAT_W'(add_v));
        write_reg(CFG_SPECULAR_GAIN, CFG_DAT_W'(gain_v));
        write_reg(CFG_LEVEL_SHIFT, CFG_DAT_W'(shift_v));
        i_cfg_wr_en <= 1'b0;
    endtask

    // Builds a texel word; maps holds the mono, red, green and blue bytes.
    function automatic t_texel texel_word(logic first, logic [31:0] surface,
                                          logic [1:0] kind, logic [31:0] maps,
                                          logic [DYN_W-1:0] dl, logic [DYN_W-1:0] dr,
                                          logic [DYN_W-1:0] dg, logic [DYN_W-1:0] db,
                                          logic tinted);
        t_texel w;
        w.first_texel   = first;
        w.surface_light = surface;
        w.map_kind      = kind;
        {w.map_level, w.map_red, w.map_green, w.map_blue} = maps;
        w.dyn_level     = dl;
        w.dyn_red       = dr;
        w.dyn_green     = dg;
        w.dyn_blue      = db;
        w.dyn_tinted    = tinted;
        return w;
    endfunction

    // Dynamic sums are mostly modest, so that the inverted channels stay off
    // their floor, and now and then take any 24-bit value.
    function automatic logic [DYN_W-1:0] dyn_sum();
        if ($urandom_range(0, 4) == 0) return DYN_W'($urandom);
        return DYN_W'($urandom_range(0, 24'h1ffff));
    endfunction

    function automatic t_texel random_texel();
        t_texel      w;
        int unsigned pick;
        w.first_texel   = ($urandom_range(0, 7) == 0);
        w.surface_light = $urandom;
        // Half the surfaces are grey, so that the coloured flag can stay clear.
        if ($urandom_range(0, 1) == 0) begin
            w.surface_light[15:8] = w.surface_light[23:16];
            w.surface_light[7:0]  = w.surface_light[23:16];
        end
        pick = $urandom_range(0, 9);
        if (pick < 3)      w.map_kind = MAP_NONE;
        else if (pick < 6) w.map_kind = MAP_MONO;
        else if (pick < 9) w.map_kind = MAP_RGB;
        else               w.map_kind = MAP_SPARE;
        {w.map_level, w.map_red, w.map_green, w.map_blue} = $urandom;
        w.dyn_level  = dyn_sum();
        w.dyn_red    = dyn_sum();
        w.dyn_green  = dyn_sum();
        w.dyn_blue   = dyn_sum();
        w.dyn_tinted = ($urandom_range(0, 5) == 0);
        return w;
    endfunction

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n        = 1'b0;
        i_cfg_wr_en    = 1'b0;
        i_cfg_index    = CFG_AMBIENT_FLOOR;
        i_cfg_data     = '0;
        texel_ch.valid = 1'b0;
        texel_ch.word  = '0;
        light_ch.ready = 1'b0;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed words under the reset settings: floor 0, clamping on,
        // default gain and no shift.
        send_texel(texel_word(1, 32'h0, MAP_NONE, 32'h0, 0, 0, 0, 0, 0));
        send_texel(texel_word(0, 32'hffffffff, MAP_RGB, 32'hffffffff,
                              24'hffffff, 24'hffffff, 24'hffffff, 24'hffffff, 1));
        // A grey surface on a fresh surface leaves the coloured flag clear,
        // and a later grey word keeps it so.
        send_texel(texel_word(1, 32'h80808080, MAP_NONE, 32'h0, 0, 0, 0, 0, 0));
        send_texel(texel_word(0, 32'h40404040, MAP_MONO, 32'h20000000, 0, 0, 0, 0, 0));
        send_texel(texel_word(0, 32'hff102030, MAP_NONE, 32'h0, 0, 0, 0, 0, 0));
        send_texel(texel_word(0, 32'h10101010, MAP_NONE, 32'h0, 0, 0, 0, 0, 0));
        // Mono map on a full surface: colour channels clamp to 0xffff.
        send_texel(texel_word(1, 32'hffffffff, MAP_MONO, 32'hff000000, 0, 0, 0, 0, 0));
        // The spare map kind behaves as no static lightmap.
        send_texel(texel_word(1, 32'h0, MAP_SPARE, 32'hffffffff, 0, 0, 0, 0, 0));
        // Boundaries: level exactly at full light, red exactly 0x10000 and
        // green one above, which sets the additive flag with a zero add.
        send_texel(texel_word(1, 32'h0, MAP_NONE, 32'h0,
                              24'h00ff00, 24'h010000, 24'h010001, 24'hffffff, 0));
        send_texel(texel_word(0, 32'h0, MAP_NONE, 32'h0,
                              24'h00feff, 24'h00fe00, 24'h000001, 24'h000100, 1));
        send_texel(texel_word(1, 32'h00ffffff, MAP_RGB, 32'h00ff0000, 0, 0, 0, 0, 0));
        send_texel(texel_word(0, 32'hff0000ff, MAP_NONE, 32'h0, 0, 0, 0, 0, 0));

        // Full ambient floor, clamping off and the largest gain: overflow
        // past 0xffff and a saturated specular add.
        wait_drained();
        load_config(8'hff, 1'b1, 18'h3ffff, 4'd0);
        send_texel(texel_word(1, 32'h00808080, MAP_NONE, 32'h0, 0, 0, 0, 0, 0));
        send_texel(texel_word(1, 32'hffffffff, MAP_MONO, 32'hff000000, 0, 0, 0, 0, 0));
        send_texel(texel_word(0, 32'h01ff00ff, MAP_RGB, 32'h00ffffff,
                              0, 24'hffffff, 0, 24'h800000, 0));

        // Largest legal shift: the floor drops to one and specular is off.
        wait_drained();
        load_config(8'h40, 1'b0, 18'h10000, 4'd8);
        send_texel(texel_word(1, 32'h0, MAP_NONE, 32'h0, 0, 0, 0, 0, 0));
        send_texel(texel_word(1, 32'hffffffff, MAP_RGB, 32'hffffffff,
                              24'hffffff, 24'hffffff, 24'hffffff, 24'hffffff, 0));
        send_texel(texel_word(0, 32'h20406080, MAP_NONE, 32'h0,
                              24'h001000, 24'h000800, 24'h000400, 24'h000200, 0));

        // A shift above eight acts as eight.
        wait_drained();
        load_config(8'h80, 1'b1, 18'h0, 4'hf);
        send_texel(texel_word(1, 32'h0, MAP_NONE, 32'h0, 0, 0, 0, 0, 0));
        send_texel(texel_word(1, 32'h80ff0000, MAP_MONO, 32'h7f000000,
                              0, 24'h020000, 0, 0, 0));

        // Zero gain with no shift: overflow still marks the surface additive.
        wait_drained();
        load_config(8'h00, 1'b0, 18'h0, 4'd0);
        send_texel(texel_word(1, 32'h0, MAP_NONE, 32'h0, 0, 24'h7fffff, 24'h010001, 0, 0));

        // Random phases: the extremes first, then random settings with the
        // shift left at zero half the time so that specular stays in play.
        for (int unsigned phase = 0; phase < PHASES; phase++) begin
            wait_drained();
            case (phase)
                0: load_config(8'h00, 1'b0, GAIN_RESET, 4'd0);
                1: load_config(8'hff, 1'b1, 18'h3ffff, 4'd0);
                2: load_config(8'h00, 1'b1, 18'h0, 4'd8);
                3: load_config(8'($urandom), 1'b0, GAIN_W'($urandom), 4'd0);
                default: load_config(8'($urandom), 1'($urandom), GAIN_W'($urandom),
                                     ($urandom_range(0, 1) == 0) ? 4'd0
                                         : SHIFT_W'($urandom_range(1, 15)));
            endcase
            steady <= (phase == 2);
            for (int unsigned n = 0; n < PHASE_WORDS; n++)
                send_texel(random_texel());
        end

        wait_drained();
        steady <= 1'b0;
        // The extra edges here catch any word the block offers beyond the last.
        repeat (4) @(posedge i_clk);

        if (ledger.faults == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
